[src/vfs_pkg.sv]
// Shared types and constants of the video frame selector.
`default_nettype none
package vfs_pkg;

  localparam int HIST_BINS  = 64;
  localparam int BIN_W      = $clog2(HIST_BINS);
  localparam int CNT_W      = 14;
  localparam logic [CNT_W-1:0] BIN_MAX = 14'd16383;

  localparam int SAMPLE_LG  = 12;  // sample target is 2^SAMPLE_LG pixels
  localparam int DIM_W      = 13;
  localparam logic [DIM_W-1:0] MAX_DIM = 13'd4096;
  localparam int POS_W      = 24;
  localparam int TOTAL_W    = 25;
  localparam int STEP_W     = TOTAL_W - SAMPLE_LG;

  localparam int TS_W       = 48;
  localparam int SEEN_W     = 32;
  localparam int KEPT_W     = 10;
  localparam int FPS_W      = 16;
  localparam int THR_W      = 16;
  localparam int SUM_W      = 20;  // 64 bins of 14 bits
  localparam int ACC_W      = 38;
  localparam int DSQ_W      = 2 * CNT_W;
  localparam int DIST_W     = 18;

  localparam int DIV_N_W    = 48;
  localparam int DIV_D_W    = 32;
  localparam int DIV_CNT_W  = $clog2(DIV_N_W);

  localparam logic [KEPT_W-1:0] DEF_LIMIT  = 10'd32;
  localparam logic [KEPT_W-1:0] DEF_TARGET = 10'd8;
  localparam logic [THR_W-1:0]  DEF_THRESH = 16'd19661;
  localparam logic [DIST_W-1:0] DIFF_CLAMP = 18'd131072;
  localparam logic [DIV_N_W-1:0] MS_PER_S  = 48'd1000;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_STRATEGY = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FPS      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_THRESH   = 3'd4;

  localparam logic [1:0] STRAT_STRIDE = 2'd0;
  localparam logic [1:0] STRAT_TIME   = 2'd1;
  localparam logic [1:0] STRAT_SCENE  = 2'd2;
  localparam logic [1:0] STRAT_ALL    = 2'd3;

  typedef struct packed {
    logic [1:0]        strategy;
    logic [KEPT_W-1:0] target_frames;
    logic [KEPT_W-1:0] frame_limit;
    logic [FPS_W-1:0]  rate_fps;
    logic [THR_W-1:0]  change_thr;
  } cfg_t;

  typedef struct packed {
    logic             release_hist;
    logic [BIN_W-1:0] raddr;
  } hist_rd_t;

endpackage
`default_nettype wire

[src/vfs_ram.sv]
// Generic single write, single read RAM with registered read data.
`default_nettype none
module vfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule
`default_nettype wire

[src/vfs_div.sv]
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module vfs_div (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [vfs_pkg::DIV_N_W-1:0] dividend,
  input  wire logic [vfs_pkg::DIV_D_W-1:0] divisor,
  output logic                             busy,
  output logic                             done,
  output logic      [vfs_pkg::DIV_N_W-1:0] quotient,
  output logic      [vfs_pkg::DIV_D_W-1:0] remainder
);

  logic [vfs_pkg::DIV_N_W-1:0]   quo_r;
  logic [vfs_pkg::DIV_D_W-1:0]   rem_r;
  logic [vfs_pkg::DIV_D_W-1:0]   dvs_r;
  logic [vfs_pkg::DIV_CNT_W-1:0] cnt_r;
  logic                          busy_r;
  logic                          done_r;
  logic [vfs_pkg::DIV_D_W:0]     trial;
  logic [vfs_pkg::DIV_D_W:0]     diff;
  logic                          ge;

  assign trial = {rem_r, quo_r[vfs_pkg::DIV_N_W-1]};
  assign ge    = trial >= {1'b0, dvs_r};
  assign diff  = trial - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        quo_r  <= dividend;
        rem_r  <= '0;
        dvs_r  <= divisor;
      end else if (busy_r) begin
        quo_r <= {quo_r[vfs_pkg::DIV_N_W-2:0], ge};
        rem_r <= ge ? diff[vfs_pkg::DIV_D_W-1:0] : trial[vfs_pkg::DIV_D_W-1:0];
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == vfs_pkg::DIV_CNT_W'(vfs_pkg::DIV_N_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign busy      = busy_r;
  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule
`default_nettype wire

[src/vfs_queue.sv]
// Two-entry queue of end-of-frame timestamps between front and back end.
`default_nettype none
module vfs_queue (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     push_valid,
  output logic                          push_ready,
  input  wire logic [vfs_pkg::TS_W-1:0] push_data,
  output logic                          pop_valid,
  input  wire logic                     pop_ready,
  output logic      [vfs_pkg::TS_W-1:0] pop_data
);

  logic [vfs_pkg::TS_W-1:0] mem_r [2];
  logic                     wr_ptr_r;
  logic                     rd_ptr_r;
  logic [1:0]               cnt_r;
  logic                     push;
  logic                     pop;

  assign push_ready = cnt_r != 2'd2;
  assign pop_valid  = cnt_r != 2'd0;
  assign pop_data   = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        mem_r[wr_ptr_r] <= push_data;
        wr_ptr_r        <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule
`default_nettype wire

[src/vfs_front.sv]
// Front end: pixel sampling and histogram build into the current-frame RAM.
`default_nettype none
module vfs_front (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [7:0]                in_red,
  input  wire logic [7:0]                in_green,
  input  wire logic [7:0]                in_blue,
  input  wire logic [vfs_pkg::DIM_W-1:0] in_frame_width,
  input  wire logic [vfs_pkg::DIM_W-1:0] in_frame_height,
  input  wire logic [vfs_pkg::TS_W-1:0]  in_timestamp_ms,
  input  wire logic                      in_last_pixel,
  output logic                           desc_valid,
  input  wire logic                      desc_ready,
  output logic      [vfs_pkg::TS_W-1:0]  desc_ts,
  input  wire vfs_pkg::hist_rd_t         hist_rd,
  output logic      [vfs_pkg::CNT_W-1:0] hist_rdata
);

  logic [vfs_pkg::DIM_W-1:0]     w_c;
  logic [vfs_pkg::DIM_W-1:0]     h_c;
  logic [2*vfs_pkg::DIM_W-1:0]   prod_c;
  logic [vfs_pkg::TOTAL_W-1:0]   total_c;
  logic [vfs_pkg::STEP_W-1:0]    shifted_c;
  logic [vfs_pkg::STEP_W-1:0]    step_c;
  logic [vfs_pkg::STEP_W-1:0]    phase_inc;
  logic [vfs_pkg::POS_W-1:0]     pos_inc;
  logic [vfs_pkg::BIN_W-1:0]     bin_c;
  logic                          sample_c;
  logic                          accept;

  logic [vfs_pkg::POS_W-1:0]     pos_r;
  logic [vfs_pkg::STEP_W-1:0]    phase_r;
  logic                          hold_r;
  logic                          s1_valid_r;
  logic                          s1_last_r;
  logic [vfs_pkg::BIN_W-1:0]     s1_bin_r;
  logic [vfs_pkg::TS_W-1:0]      s1_ts_r;
  logic                          fwd_valid_r;
  logic [vfs_pkg::BIN_W-1:0]     fwd_bin_r;
  logic [vfs_pkg::CNT_W-1:0]     fwd_data_r;
  logic [vfs_pkg::HIST_BINS-1:0] cur_valid_r;
  logic                          bvalid_r;
  logic                          desc_valid_r;
  logic [vfs_pkg::TS_W-1:0]      desc_ts_r;

  logic [vfs_pkg::BIN_W-1:0]     ram_raddr;
  logic [vfs_pkg::CNT_W-1:0]     ram_rdata;
  logic [vfs_pkg::CNT_W-1:0]     old_c;
  logic [vfs_pkg::CNT_W-1:0]     new_c;

  assign w_c       = (in_frame_width > vfs_pkg::MAX_DIM) ? vfs_pkg::MAX_DIM : in_frame_width;
  assign h_c       = (in_frame_height > vfs_pkg::MAX_DIM) ? vfs_pkg::MAX_DIM : in_frame_height;
  assign prod_c    = w_c * h_c;
  assign total_c   = prod_c[vfs_pkg::TOTAL_W-1:0];
  assign shifted_c = total_c[vfs_pkg::TOTAL_W-1:vfs_pkg::SAMPLE_LG];
  assign step_c    = (shifted_c == '0) ? vfs_pkg::STEP_W'(1) : shifted_c;
  assign sample_c  = ({1'b0, pos_r} < total_c) && (phase_r == '0);
  assign bin_c     = {in_red[7:6], in_green[7:6], in_blue[7:6]};
  assign pos_inc   = pos_r + 1'b1;
  assign phase_inc = phase_r + 1'b1;

  assign in_ready  = !hold_r;
  assign accept    = in_valid && in_ready;

  // one-deep forward covers the write that lands on the same edge as the read
  assign old_c = (fwd_valid_r && fwd_bin_r == s1_bin_r) ? fwd_data_r :
                 (cur_valid_r[s1_bin_r] ? ram_rdata : '0);
  assign new_c = (old_c == vfs_pkg::BIN_MAX) ? old_c : old_c + 1'b1;

  assign ram_raddr = hold_r ? hist_rd.raddr : bin_c;

  vfs_ram #(
    .WIDTH (vfs_pkg::CNT_W),
    .DEPTH (vfs_pkg::HIST_BINS)
  ) u_cur_ram (
    .clk   (clk),
    .we    (s1_valid_r),
    .waddr (s1_bin_r),
    .wdata (new_c),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r        <= '0;
      phase_r      <= '0;
      hold_r       <= 1'b0;
      s1_valid_r   <= 1'b0;
      s1_last_r    <= 1'b0;
      fwd_valid_r  <= 1'b0;
      cur_valid_r  <= '0;
      desc_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= accept && sample_c;
      s1_last_r   <= accept && in_last_pixel;
      fwd_valid_r <= s1_valid_r;
      if (accept) begin
        if (in_last_pixel) begin
          pos_r   <= '0;
          phase_r <= '0;
          hold_r  <= 1'b1;
        end else begin
          pos_r   <= pos_inc;
          // position wraps to zero, and so does the sampling phase
          phase_r <= (pos_inc == '0 || phase_inc >= step_c) ? '0 : phase_inc;
        end
      end
      if (s1_valid_r) begin
        cur_valid_r[s1_bin_r] <= 1'b1;
      end
      if (s1_last_r) begin
        desc_valid_r <= 1'b1;
      end else if (desc_ready) begin
        desc_valid_r <= 1'b0;
      end
      if (hist_rd.release_hist) begin
        hold_r      <= 1'b0;
        cur_valid_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_bin_r <= bin_c;
      s1_ts_r  <= in_timestamp_ms;
    end
    fwd_bin_r  <= s1_bin_r;
    fwd_data_r <= new_c;
    bvalid_r   <= cur_valid_r[ram_raddr];
    if (s1_last_r) begin
      desc_ts_r <= s1_ts_r;
    end
  end

  assign desc_valid = desc_valid_r;
  assign desc_ts    = desc_ts_r;
  assign hist_rdata = bvalid_r ? ram_rdata : '0;

  a_desc_in_hold : assert property (@(posedge clk) disable iff (!rst_n)
    desc_valid_r |-> hold_r)
    else $error("frame word queued while front end accepts pixels");

  a_release_drained : assert property (@(posedge clk) disable iff (!rst_n)
    hist_rd.release_hist |-> (hold_r && !desc_valid_r && !s1_valid_r))
    else $error("histogram released with frame work still pending");

endmodule
`default_nettype wire

[src/vfs_back.sv]
// Back end: per-frame decision, scene distance sweep and result register.
`default_nettype none
module vfs_back (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire vfs_pkg::cfg_t              cfg,
  input  wire logic                       desc_valid,
  output logic                            desc_ready,
  input  wire logic [vfs_pkg::TS_W-1:0]   desc_ts,
  output vfs_pkg::hist_rd_t               hist_rd,
  input  wire logic [vfs_pkg::CNT_W-1:0]  hist_rdata,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic                            out_selected,
  output logic      [vfs_pkg::SEEN_W-1:0] out_frames_seen,
  output logic      [vfs_pkg::KEPT_W-1:0] out_frames_kept
);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_DECIDE = 4'd1;
  localparam logic [3:0] ST_STR_Q  = 4'd2;
  localparam logic [3:0] ST_STR_R  = 4'd3;
  localparam logic [3:0] ST_TIME   = 4'd4;
  localparam logic [3:0] ST_RD     = 4'd5;
  localparam logic [3:0] ST_DAT    = 4'd6;
  localparam logic [3:0] ST_MUL    = 4'd7;
  localparam logic [3:0] ST_BDIV   = 4'd8;
  localparam logic [3:0] ST_BWAIT  = 4'd9;
  localparam logic [3:0] ST_NORM   = 4'd10;
  localparam logic [3:0] ST_NWAIT  = 4'd11;
  localparam logic [3:0] ST_DONE   = 4'd12;

  logic [3:0]                    state_r;
  logic [vfs_pkg::SEEN_W-1:0]    seen_r;
  logic [vfs_pkg::KEPT_W-1:0]    kept_r;
  logic                          have_prev_r;
  logic [vfs_pkg::TS_W-1:0]      last_time_r;
  logic [vfs_pkg::TS_W-1:0]      ts_r;
  logic                          sel_r;
  logic [vfs_pkg::BIN_W-1:0]     idx_r;
  logic                          copy_only_r;
  logic [vfs_pkg::CNT_W-1:0]     d_r;
  logic [vfs_pkg::CNT_W:0]       s_r;
  logic [vfs_pkg::DSQ_W-1:0]     dsq_r;
  logic [vfs_pkg::SUM_W-1:0]     sa_r;
  logic [vfs_pkg::SUM_W-1:0]     sb_r;
  logic [vfs_pkg::ACC_W-1:0]     acc_r;
  logic [vfs_pkg::HIST_BINS-1:0] prev_valid_r;
  logic                          pvalid_q_r;
  logic                          out_valid_r;
  logic                          out_sel_r;
  logic [vfs_pkg::SEEN_W-1:0]    out_seen_r;
  logic [vfs_pkg::KEPT_W-1:0]    out_kept_r;

  logic [vfs_pkg::KEPT_W-1:0]    limit_c;
  logic [vfs_pkg::KEPT_W-1:0]    target_c;
  logic [vfs_pkg::KEPT_W-1:0]    target_lim_c;
  logic [vfs_pkg::THR_W-1:0]     thr_c;
  logic [vfs_pkg::CNT_W-1:0]     prev_rdata;
  logic [vfs_pkg::CNT_W-1:0]     a_c;
  logic [vfs_pkg::CNT_W-1:0]     b_c;
  logic [vfs_pkg::SUM_W-1:0]     norm_c;
  logic [vfs_pkg::KEPT_W-1:0]    interval_c;
  logic                          time_ok_c;
  logic [vfs_pkg::DIST_W-1:0]    clamp_c;
  logic                          last_bin_c;
  logic                          slot_free;
  logic                          load_out;
  logic [vfs_pkg::KEPT_W-1:0]    kept_nxt;

  logic                          div_start;
  logic [vfs_pkg::DIV_N_W-1:0]   div_n;
  logic [vfs_pkg::DIV_D_W-1:0]   div_d;
  logic                          div_busy;
  logic                          div_done;
  logic [vfs_pkg::DIV_N_W-1:0]   div_quo;
  logic [vfs_pkg::DIV_D_W-1:0]   div_rem;

  assign limit_c      = (cfg.frame_limit == '0) ? vfs_pkg::DEF_LIMIT : cfg.frame_limit;
  assign target_c     = (cfg.target_frames == '0) ? vfs_pkg::DEF_TARGET : cfg.target_frames;
  assign target_lim_c = (target_c > limit_c) ? limit_c : target_c;
  assign thr_c        = (cfg.change_thr == '0) ? vfs_pkg::DEF_THRESH
                                               : cfg.change_thr;

  assign a_c    = pvalid_q_r ? prev_rdata : '0;
  assign b_c    = hist_rdata;
  assign norm_c = (sa_r > sb_r) ? sa_r : sb_r;

  // quotient of 1000/fps fits in ten bits; a zero interval counts as one
  assign interval_c = (div_quo == '0) ? vfs_pkg::KEPT_W'(1) : div_quo[vfs_pkg::KEPT_W-1:0];
  assign time_ok_c  = !have_prev_r ||
                      ({1'b0, ts_r} >= ({1'b0, last_time_r} +
                                        (vfs_pkg::TS_W + 1)'(interval_c)));
  assign clamp_c    = (div_quo > vfs_pkg::DIV_N_W'(vfs_pkg::DIFF_CLAMP)) ?
                      vfs_pkg::DIFF_CLAMP : div_quo[vfs_pkg::DIST_W-1:0];
  assign last_bin_c = idx_r == vfs_pkg::BIN_W'(vfs_pkg::HIST_BINS - 1);

  assign slot_free  = !out_valid_r || out_ready;
  assign load_out   = (state_r == ST_DONE) && slot_free;
  assign kept_nxt   = kept_r + {{(vfs_pkg::KEPT_W-1){1'b0}}, sel_r};
  assign desc_ready = state_r == ST_IDLE;

  assign hist_rd.release_hist = load_out;
  assign hist_rd.raddr        = idx_r;

  always_comb begin
    div_start = 1'b0;
    div_n     = '0;
    div_d     = '0;
    case (state_r)
      ST_DECIDE: begin
        if (cfg.strategy == vfs_pkg::STRAT_TIME) begin
          div_n = vfs_pkg::MS_PER_S;
          div_d = vfs_pkg::DIV_D_W'(cfg.rate_fps);
          div_start = (kept_r < limit_c) && (cfg.rate_fps != '0);
        end else begin
          div_n = vfs_pkg::DIV_N_W'(seen_r);
          div_d = vfs_pkg::DIV_D_W'(cfg.target_frames);
          div_start = (cfg.strategy == vfs_pkg::STRAT_STRIDE) && (kept_r < limit_c) &&
                      (kept_r < target_lim_c) && (cfg.target_frames != '0) &&
                      (seen_r != '0) && (kept_r != '0) &&
                      (vfs_pkg::SEEN_W'(cfg.target_frames) < seen_r);
        end
      end
      ST_STR_Q: begin
        div_n     = vfs_pkg::DIV_N_W'(seen_r);
        div_d     = div_quo[vfs_pkg::DIV_D_W-1:0];
        div_start = div_done && (div_quo > vfs_pkg::DIV_N_W'(1));
      end
      ST_BDIV: begin
        div_n     = vfs_pkg::DIV_N_W'({dsq_r, 16'b0});
        div_d     = vfs_pkg::DIV_D_W'(s_r);
        div_start = s_r != '0;
      end
      ST_NORM: begin
        div_n     = vfs_pkg::DIV_N_W'(acc_r);
        div_d     = vfs_pkg::DIV_D_W'(norm_c);
        div_start = (sa_r != '0) || (sb_r != '0);
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  vfs_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_n),
    .divisor   (div_d),
    .busy      (div_busy),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  vfs_ram #(
    .WIDTH (vfs_pkg::CNT_W),
    .DEPTH (vfs_pkg::HIST_BINS)
  ) u_prev_ram (
    .clk   (clk),
    .we    (state_r == ST_DAT),
    .waddr (idx_r),
    .wdata (b_c),
    .raddr (idx_r),
    .rdata (prev_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      seen_r       <= '0;
      kept_r       <= '0;
      have_prev_r  <= 1'b0;
      last_time_r  <= '0;
      prev_valid_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (desc_valid) begin
            seen_r  <= seen_r + 1'b1;
            state_r <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          idx_r   <= '0;
          sa_r    <= '0;
          sb_r    <= '0;
          acc_r   <= '0;
          sel_r   <= 1'b1;
          state_r <= ST_DONE;
          if (kept_r >= limit_c) begin
            sel_r <= 1'b0;
          end else begin
            case (cfg.strategy)
              vfs_pkg::STRAT_STRIDE: begin
                if (kept_r >= target_lim_c) begin
                  sel_r <= 1'b0;
                end else if (div_start) begin
                  state_r <= ST_STR_Q;
                end
              end
              vfs_pkg::STRAT_TIME: begin
                if (div_start) begin
                  state_r <= ST_TIME;
                end
              end
              vfs_pkg::STRAT_SCENE: begin
                copy_only_r <= !have_prev_r;
                state_r     <= ST_RD;
              end
              default: begin
                sel_r <= 1'b1;
              end
            endcase
          end
        end
        ST_STR_Q: begin
          if (div_done) begin
            // a stride of one keeps every frame
            state_r <= div_start ? ST_STR_R : ST_DONE;
          end
        end
        ST_STR_R: begin
          if (div_done) begin
            sel_r   <= div_rem == '0;
            state_r <= ST_DONE;
          end
        end
        ST_TIME: begin
          if (div_done) begin
            sel_r <= time_ok_c;
            if (time_ok_c) begin
              last_time_r <= ts_r;
              have_prev_r <= 1'b1;
            end
            state_r <= ST_DONE;
          end
        end
        ST_RD: begin
          state_r <= ST_DAT;
        end
        ST_DAT: begin
          prev_valid_r[idx_r] <= 1'b1;
          sa_r <= sa_r + vfs_pkg::SUM_W'(a_c);
          sb_r <= sb_r + vfs_pkg::SUM_W'(b_c);
          if (copy_only_r) begin
            if (last_bin_c) begin
              have_prev_r <= 1'b1;
              sel_r       <= 1'b1;
              state_r     <= ST_DONE;
            end else begin
              idx_r   <= idx_r + 1'b1;
              state_r <= ST_RD;
            end
          end else begin
            state_r <= ST_MUL;
          end
        end
        ST_MUL: begin
          state_r <= ST_BDIV;
        end
        ST_BDIV: begin
          if (div_start) begin
            state_r <= ST_BWAIT;
          end else if (last_bin_c) begin
            state_r <= ST_NORM;
          end else begin
            idx_r   <= idx_r + 1'b1;
            state_r <= ST_RD;
          end
        end
        ST_BWAIT: begin
          if (div_done) begin
            acc_r <= acc_r + div_quo[vfs_pkg::ACC_W-1:0];
            if (last_bin_c) begin
              state_r <= ST_NORM;
            end else begin
              idx_r   <= idx_r + 1'b1;
              state_r <= ST_RD;
            end
          end
        end
        ST_NORM: begin
          if (div_start) begin
            state_r <= ST_NWAIT;
          end else begin
            // both histograms empty: distance is zero
            sel_r   <= thr_c == '0;
            state_r <= ST_DONE;
          end
        end
        ST_NWAIT: begin
          if (div_done) begin
            sel_r   <= {1'b0, clamp_c[vfs_pkg::DIST_W-1:1]} >= {2'b0, thr_c};
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (slot_free) begin
            kept_r      <= kept_nxt;
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && desc_valid) begin
      ts_r <= desc_ts;
    end
    if (state_r == ST_RD) begin
      pvalid_q_r <= prev_valid_r[idx_r];
    end
    if (state_r == ST_DAT) begin
      d_r <= (a_c >= b_c) ? a_c - b_c : b_c - a_c;
      s_r <= {1'b0, a_c} + {1'b0, b_c};
    end
    if (state_r == ST_MUL) begin
      dsq_r <= d_r * d_r;
    end
    if (load_out) begin
      out_sel_r  <= sel_r;
      out_seen_r <= seen_r;
      out_kept_r <= kept_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_selected    = out_sel_r;
  assign out_frames_seen = out_seen_r;
  assign out_frames_kept = out_kept_r;

  a_div_idle_start : assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  a_release_loads : assert property (@(posedge clk) disable iff (!rst_n)
    hist_rd.release_hist |=> out_valid_r)
    else $error("histogram released without a result word");

  a_kept_on_load : assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(kept_r) |-> $past(load_out))
    else $error("kept count changed outside result load");

endmodule
`default_nettype wire

[src/video_frame_selector.sv]
// Top level of the video frame selector: config registers, front, queue, back.
//
// Pixels are taken one per clock while a frame streams in; every step-th pixel
// goes into a 64-bin color histogram held in a small RAM with a one-deep
// forward for back-to-back hits on the same bin. The word with last_pixel set
// ends the frame: the input then stalls until the back end has made its
// decision and has loaded the result register, and the histogram is cleared
// at once through per-bin valid bits, with no clearing pass. The back end's
// time is set by a shared divider: uniform stride divides at most twice, time
// interval at most once and accept all not at all, the first scene frame copies
// the histogram bin by bin, and a scene comparison sweeps both histograms bin by
// bin, dividing once per non-empty bin and once more to normalize.
// A finished result waits in the output register while the next frame's
// pixels are already being taken.
`default_nettype none
module video_frame_selector (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [7:0]                     in_red,
  input  wire logic [7:0]                     in_green,
  input  wire logic [7:0]                     in_blue,
  input  wire logic [vfs_pkg::DIM_W-1:0]      in_frame_width,
  input  wire logic [vfs_pkg::DIM_W-1:0]      in_frame_height,
  input  wire logic [vfs_pkg::TS_W-1:0]       in_timestamp_ms,
  input  wire logic                           in_last_pixel,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic                                out_selected,
  output logic      [vfs_pkg::SEEN_W-1:0]     out_frames_seen,
  output logic      [vfs_pkg::KEPT_W-1:0]     out_frames_kept,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [vfs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [vfs_pkg::CFG_DATA_W-1:0] cfg_data
);

  vfs_pkg::cfg_t             cfg_r;
  vfs_pkg::hist_rd_t         hist_rd;
  logic [vfs_pkg::CNT_W-1:0] hist_rdata;
  logic                      fq_valid;
  logic                      fq_ready;
  logic [vfs_pkg::TS_W-1:0]  fq_ts;
  logic                      qb_valid;
  logic                      qb_ready;
  logic [vfs_pkg::TS_W-1:0]  qb_ts;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.strategy      <= vfs_pkg::STRAT_STRIDE;
      cfg_r.target_frames <= '0;
      cfg_r.frame_limit   <= vfs_pkg::DEF_LIMIT;
      cfg_r.rate_fps      <= '0;
      cfg_r.change_thr    <= vfs_pkg::DEF_THRESH;
    end else if (cfg_valid) begin
      case (cfg_index)
        vfs_pkg::REG_STRATEGY: cfg_r.strategy      <= cfg_data[1:0];
        vfs_pkg::REG_TARGET:   cfg_r.target_frames <= cfg_data[vfs_pkg::KEPT_W-1:0];
        vfs_pkg::REG_LIMIT:    cfg_r.frame_limit   <= cfg_data[vfs_pkg::KEPT_W-1:0];
        vfs_pkg::REG_FPS:      cfg_r.rate_fps      <= cfg_data;
        vfs_pkg::REG_THRESH:   cfg_r.change_thr    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  vfs_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_red          (in_red),
    .in_green        (in_green),
    .in_blue         (in_blue),
    .in_frame_width  (in_frame_width),
    .in_frame_height (in_frame_height),
    .in_timestamp_ms (in_timestamp_ms),
    .in_last_pixel   (in_last_pixel),
    .desc_valid      (fq_valid),
    .desc_ready      (fq_ready),
    .desc_ts         (fq_ts),
    .hist_rd         (hist_rd),
    .hist_rdata      (hist_rdata)
  );

  vfs_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_data  (fq_ts),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_data   (qb_ts)
  );

  vfs_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .desc_valid      (qb_valid),
    .desc_ready      (qb_ready),
    .desc_ts         (qb_ts),
    .hist_rd         (hist_rd),
    .hist_rdata      (hist_rdata),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_selected    (out_selected),
    .out_frames_seen (out_frames_seen),
    .out_frames_kept (out_frames_kept)
  );

endmodule
`default_nettype wire

[bench/vfs_checker.sv]
// Checker for the video frame selector: tracks the channels, predicts each frame verdict, compares.
`timescale 1ns / 1ps
module vfs_checker
  import vfs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [7:0]            in_red,
  input  logic [7:0]            in_green,
  input  logic [7:0]            in_blue,
  input  logic [DIM_W-1:0]      in_frame_width,
  input  logic [DIM_W-1:0]      in_frame_height,
  input  logic [TS_W-1:0]       in_timestamp_ms,
  input  logic                  in_last_pixel,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic                  out_selected,
  input  logic [SEEN_W-1:0]     out_frames_seen,
  input  logic [KEPT_W-1:0]     out_frames_kept,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    pending
);

  typedef struct {
    logic              sel;
    logic [SEEN_W-1:0] seen;
    logic [KEPT_W-1:0] kept;
  } verdict_t;

  verdict_t          frame_verdicts[$];
  cfg_t              regs;
  logic [CNT_W-1:0]  cur_hist[HIST_BINS];
  logic [CNT_W-1:0]  old_hist[HIST_BINS];
  bit                have_prev;
  logic [TS_W-1:0]   last_kept_ts;
  logic [SEEN_W-1:0] seen_cnt;
  logic [KEPT_W-1:0] kept_cnt;
  logic [POS_W-1:0]  pix_pos;

  function automatic longint unsigned chi_square_dist();
    longint unsigned sa, sb, acc, norm, a, b, d;
    sa = 0;
    sb = 0;
    acc = 0;
    for (int i = 0; i < HIST_BINS; i++) begin
      sa += old_hist[i];
      sb += cur_hist[i];
    end
    if (sa == 0 && sb == 0) return 0;
    norm = (sa > sb) ? sa : sb;
    for (int i = 0; i < HIST_BINS; i++) begin
      a = old_hist[i];
      b = cur_hist[i];
      d = (a > b) ? a - b : b - a;
      if (a + b > 0) acc += ((d * d) << 16) / (a + b);
    end
    acc = acc / norm;
    if (acc > 131072) acc = 131072;
    return acc >> 1;
  endfunction

  function automatic bit keep_frame(input logic [TS_W-1:0] ts);
    int unsigned     limit, target, stride, thr;
    longint unsigned interval;
    limit = (regs.frame_limit != 0) ? regs.frame_limit : DEF_LIMIT;
    if (kept_cnt >= limit) return 0;
    case (regs.strategy)
      STRAT_STRIDE: begin
        target = (regs.target_frames != 0) ? regs.target_frames : DEF_TARGET;
        if (target > limit) target = limit;
        if (kept_cnt >= target) return 0;
        if (regs.target_frames != 0 && seen_cnt != 0) begin
          stride = 1;
          if (regs.target_frames < seen_cnt) stride = seen_cnt / regs.target_frames;
          if (stride == 0) stride = 1;
          if (kept_cnt == 0) return 1;
          return (seen_cnt % stride) == 0;
        end
        return 1;
      end
      STRAT_TIME: begin
        if (regs.rate_fps == 0) return 1;
        interval = 1000 / regs.rate_fps;
        if (interval == 0) interval = 1;
        if (!have_prev || 64'(ts) >= 64'(last_kept_ts) + interval) begin
          last_kept_ts = ts;
          have_prev = 1;
          return 1;
        end
        return 0;
      end
      STRAT_SCENE: begin
        thr = (regs.change_thr != 0) ? regs.change_thr : DEF_THRESH;
        if (!have_prev) begin
          old_hist = cur_hist;
          have_prev = 1;
          return 1;
        end
        interval = chi_square_dist();
        old_hist = cur_hist;
        return interval >= thr;
      end
      default: return 1;
    endcase
  endfunction

  task automatic take_pixel();
    int unsigned w, h, total, step;
    logic [BIN_W-1:0] bin;
    verdict_t v;
    w = (in_frame_width > MAX_DIM) ? MAX_DIM : in_frame_width;
    h = (in_frame_height > MAX_DIM) ? MAX_DIM : in_frame_height;
    total = w * h;
    step = total >> SAMPLE_LG;
    if (step == 0) step = 1;
    if (pix_pos < total && (pix_pos % step) == 0) begin
      bin = {in_red[7:6], in_green[7:6], in_blue[7:6]};
      if (cur_hist[bin] < BIN_MAX) cur_hist[bin]++;
    end
    pix_pos++;
    if (in_last_pixel) begin
      seen_cnt++;
      v.sel = keep_frame(in_timestamp_ms);
      if (v.sel) kept_cnt++;
      v.seen = seen_cnt;
      v.kept = kept_cnt;
      frame_verdicts.push_back(v);
      foreach (cur_hist[i]) cur_hist[i] = '0;
      pix_pos = '0;
    end
  endtask

  always @(posedge clk) begin
    verdict_t v;
    if (!rst_n) begin
      regs = '{strategy: STRAT_STRIDE, target_frames: '0, frame_limit: DEF_LIMIT,
               rate_fps: '0, change_thr: DEF_THRESH};
      foreach (cur_hist[i]) cur_hist[i] = '0;
      foreach (old_hist[i]) old_hist[i] = '0;
      have_prev = 0;
      last_kept_ts = '0;
      seen_cnt = '0;
      kept_cnt = '0;
      pix_pos = '0;
      frame_verdicts.delete();
      fail_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_STRATEGY: regs.strategy = cfg_data[1:0];
          REG_TARGET:   regs.target_frames = cfg_data[KEPT_W-1:0];
          REG_LIMIT:    regs.frame_limit = cfg_data[KEPT_W-1:0];
          REG_FPS:      regs.rate_fps = cfg_data;
          REG_THRESH:   regs.change_thr = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (frame_verdicts.size() == 0) begin
          $error("unexpected result word: selected %0d seen %0d kept %0d",
                 out_selected, out_frames_seen, out_frames_kept);
          fail_count++;
        end else begin
          v = frame_verdicts.pop_front();
          if (out_selected !== v.sel) begin
            $error("selected: expected %0d, actual %0d", v.sel, out_selected);
            fail_count++;
          end
          if (out_frames_seen !== v.seen) begin
            $error("frames_seen: expected %0d, actual %0d", v.seen, out_frames_seen);
            fail_count++;
          end
          if (out_frames_kept !== v.kept) begin
            $error("frames_kept: expected %0d, actual %0d", v.kept, out_frames_kept);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) take_pixel();
    end
    pending = frame_verdicts.size();
  end

endmodule

[bench/tb.sv]
// Testbench top for the video frame selector: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb;
  import vfs_pkg::*;

  logic                  clk;
  logic                  rst_n = 0;
  logic                  in_valid = 0;
  logic                  in_ready;
  logic [7:0]            in_red = '0, in_green = '0, in_blue = '0;
  logic [DIM_W-1:0]      in_frame_width = '0, in_frame_height = '0;
  logic [TS_W-1:0]       in_timestamp_ms = '0;
  logic                  in_last_pixel = 0;
  logic                  out_valid;
  logic                  out_ready = 0;
  logic                  out_selected;
  logic [SEEN_W-1:0]     out_frames_seen;
  logic [KEPT_W-1:0]     out_frames_kept;
  logic                  cfg_valid = 0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int                    fail_count;
  int                    pending;

  int       burst_left = 0;
  int       pixels_sent = 0;
  bit       hold_req = 0;
  logic [TS_W-1:0] ts_now = '0;

  video_frame_selector i_dut (.*);
  vfs_checker i_checker (.*);

  always begin
    clk = 1;
    #10;
    clk = 0;
    #10;
  end

  // watchdog: cycles with no word moving on any channel
  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle = 0;
      else idle++;
      if (idle >= 40000) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // receiver: stall pattern is picked at random over and over; one long hold when asked
  initial begin
    int mode;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      mode = $urandom_range(0, 3);
      for (int i = 0; i < 64; i++) begin
        if (hold_req) begin
          hold_req = 0;
          out_ready <= 0;
          repeat (400) @(posedge clk);
        end
        case (mode)
          0, 1: out_ready <= 1;
          2: out_ready <= 1'($urandom_range(0, 1));
          default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
        @(posedge clk);
      end
    end
  end

  task automatic send_pixel(logic [7:0] r, g, b, logic [DIM_W-1:0] w, h,
                            logic [TS_W-1:0] ts, logic last);
    bit rdy;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 2) != 0) begin
        in_valid <= 0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    in_valid <= 1;
    in_red <= r;
    in_green <= g;
    in_blue <= b;
    in_frame_width <= w;
    in_frame_height <= h;
    in_timestamp_ms <= ts;
    in_last_pixel <= last;
    do begin
      @(negedge clk);
      rdy = in_ready;
      @(posedge clk);
    end while (!rdy);
    burst_left--;
    pixels_sent++;
  endtask

  // style 0: random colors; else mostly one base color (scene stays put unless base moves)
  task automatic send_frame(int npx, logic [DIM_W-1:0] w, h, logic [TS_W-1:0] ts, int style);
    logic [23:0] base, c;
    base = $urandom;
    for (int i = 0; i < npx; i++) begin
      c = (style == 0 || $urandom_range(0, 5) == 0) ? 24'($urandom) : base;
      send_pixel(c[23:16], c[15:8], c[7:0], w, h, ts, i == npx - 1);
    end
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(negedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    bit rdy;
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    do begin
      @(negedge clk);
      rdy = cfg_ready;
      @(posedge clk);
    end while (!rdy);
  endtask

  task automatic set_regs(logic [1:0] strat, int target, limit, fps, thr);
    drain();
    write_reg(REG_STRATEGY, 16'(strat));
    write_reg(REG_TARGET, 16'(target));
    write_reg(REG_LIMIT, 16'(limit));
    write_reg(REG_FPS, 16'(fps));
    write_reg(REG_THRESH, 16'(thr));
    cfg_valid <= 0;
  endtask

  task automatic random_frame(int style);
    int npx, w, h;
    case ($urandom_range(0, 7))
      0: begin w = $urandom_range(0, 8191); h = $urandom_range(0, 8191); end
      1: begin w = 0; h = $urandom_range(1, 8); end
      2: begin w = $urandom_range(64, 200); h = $urandom_range(64, 200); end
      default: begin w = $urandom_range(1, 6); h = $urandom_range(1, 5); end
    endcase
    npx = (w * h >= 1 && w * h <= 40) ? w * h + $urandom_range(0, 2) : $urandom_range(1, 20);
    if ($urandom_range(0, 9) == 0 && npx > 1) npx = npx - 1;
    case ($urandom_range(0, 9))
      0: ts_now = TS_W'({$urandom, $urandom});
      1: ts_now = '1;
      default: ts_now = ts_now + $urandom_range(0, 1200);
    endcase
    send_frame(npx, DIM_W'(w), DIM_W'(h), ts_now, style);
  endtask

  function automatic int pick(int a, b, c, d);
    case ($urandom_range(0, 4))
      0: return a;
      1: return b;
      2: return c;
      3: return d;
      default: return -1;
    endcase
  endfunction

  initial begin
    int target, limit, fps, thr, style;
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: reset settings, field extremes, zero and oversized sizes, extra pixels
    send_frame(1, 1, 1, '0, 1);
    send_pixel(8'hff, 8'hff, 8'hff, 13'h1fff, 13'h1fff, '1, 1);
    send_frame(3, 0, 5, 48'd10, 0);
    send_frame(3, 4096, 4096, 48'd20, 0);
    send_frame(2, 4097, 1, 48'd30, 0);
    send_frame(6, 2, 2, 48'd40, 0);
    set_regs(STRAT_SCENE, 1023, 1023, 0, 0);
    send_frame(4, 2, 2, 48'd50, 1);
    send_frame(4, 2, 2, 48'd60, 1);
    set_regs(STRAT_SCENE, 0, 1023, 65535, 65535);
    send_frame(3, 3, 1, 48'd70, 1);
    set_regs(STRAT_TIME, 1, 1023, 1, 1);
    send_frame(1, 1, 1, 48'd1000, 1);
    send_frame(1, 1, 1, 48'd1999, 1);
    set_regs(STRAT_TIME, 1, 1023, 65535, 1);
    send_frame(1, 1, 1, 48'd2000, 1);
    send_frame(1, 1, 1, 48'd2000, 1);
    // limit reached: scene not compared, accept-all blocked
    set_regs(STRAT_ALL, 0, 1, 0, 0);
    send_frame(1, 1, 1, 48'd3000, 1);
    set_regs(STRAT_SCENE, 0, 1, 0, 0);
    send_frame(1, 1, 1, 48'd3001, 1);

    // pressure: receiver holds off while tiny frames keep coming
    set_regs(STRAT_ALL, 0, 1023, 0, 0);
    hold_req = 1;
    repeat (8) send_frame(1, 1, 1, 48'd4000, 0);

    while (pixels_sent < 670) begin
      target = pick(0, 1, 1023, $urandom_range(2, 12));
      if (target < 0) target = $urandom_range(0, 1023);
      limit = pick(0, 1023, 1023, $urandom_range(1, 100));
      if (limit < 0) limit = $urandom_range(0, 1023);
      fps = pick(0, 1, 1000, 65535);
      if (fps < 0) fps = pick(30, 999, 1001, $urandom_range(0, 65535));
      if (fps < 0) fps = $urandom_range(2, 500);
      thr = pick(0, 1, 65535, 19661);
      if (thr < 0) thr = $urandom_range(0, 65535);
      set_regs(2'($urandom_range(0, 3)), target, limit, fps, thr);
      style = $urandom_range(0, 2);
      repeat ($urandom_range(2, 8)) random_frame(style);
    end

    drain();
    if (fail_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
